>>> hw/rtl/fractional_baud_divider_calc_macros.svh
// ---------------------------------------------------------------------------
// fractional baud divider calc - assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ---------------------------------------------------------------------------
`ifndef FRACTIONAL_BAUD_DIVIDER_CALC_MACROS_SVH
`define FRACTIONAL_BAUD_DIVIDER_CALC_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define FBD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// expression must never be true outside reset
`define FBD_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define FBD_ASSERT(label, clk, rst, prop, msg)
`define FBD_NEVER(label, clk, rst, expr, msg)
`endif
`endif

>>> hw/rtl/fbd_pkg.sv
// ---------------------------------------------------------------------------
// fbd_pkg
// shared types, constants and the exponent limit table of the baud divider
// ---------------------------------------------------------------------------
package fbd_pkg;

   localparam int DataW = 32;
   localparam int PaddrW = 3;
   localparam int DivisorW = 12;
   localparam int ScaleW = 4;
   localparam int DivCountW = 5;

   localparam logic [DataW-1:0] ClockHzReset = 32'd2000000;
   localparam logic DoubleSpeedReset = 1'b0;

   // clock/8 and clock/4194304 as shifts
   localparam int MaxRateShift = 3;
   localparam int MinRateShift = 22;

   // exponents -7..6 are tested, 7 is the fallback
   localparam int ExpSteps = 14;
   localparam logic signed [ScaleW-1:0] ExpLow = -4'sd7;
   localparam logic signed [ScaleW-1:0] ExpLowBand = -4'sd3;
   localparam logic [ScaleW-1:0] ExpBias = 4'd3;

   localparam logic [DataW-1:0] LimitBase = 32'h0000_0FFF >> 4;
   localparam logic [DataW-1:0] LimitTop = 32'h0000_0FFF;

   typedef enum logic {
      REG_CLOCK_HZ     = 1'b0,
      REG_DOUBLE_SPEED = 1'b1
   } reg_idx_type;

   typedef struct packed {
      logic start;
   } div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // limit tested at search step idx (exponent idx-7)
   function automatic logic [DataW-1:0] exp_limit(input logic [ScaleW-1:0] idx);
      logic [DataW-1:0] lim;
      if (idx <= 4'd4) begin
         lim = ((LimitBase + 32'd1) << idx) - 32'd1;
      end else begin
         lim = LimitTop << (idx - 4'd4);
      end
      return lim;
   endfunction

endpackage

>>> hw/rtl/fbd_req_if.sv
// ---------------------------------------------------------------------------
// fbd_req_if
// request channel: one requested baud rate per item
// ---------------------------------------------------------------------------
interface fbd_req_if import fbd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [DataW-1:0] baud;

   modport source (output valid, output baud, input ready);
   modport sink (input valid, input baud, output ready);
endinterface

>>> hw/rtl/fbd_rsp_if.sv
// ---------------------------------------------------------------------------
// fbd_rsp_if
// response channel: accept flag, divisor and scale exponent per item
// ---------------------------------------------------------------------------
interface fbd_rsp_if import fbd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     accepted;
   logic [DivisorW-1:0]      divisor;
   logic signed [ScaleW-1:0] scale_exp;

   modport source (output valid, output accepted, output divisor, output scale_exp,
                   input ready);
   modport sink (input valid, input accepted, input divisor, input scale_exp,
                 output ready);
endinterface

>>> hw/rtl/fractional_baud_divider_calc.sv
// ---------------------------------------------------------------------------
// fractional_baud_divider_calc
// baud select / scale calculation for a fractional baud generator
//
//   channel   dir  handshake      payload
//   req_bus   in   valid/ready    baud
//   rsp_bus   out  valid/ready    accepted, divisor, scale_exp
//   apb       in   psel/penable   clock_hz (0x0), double_speed (0x4)
//
// an accepted rate takes two passes of the shared divider (clock/baud, then the
// rounded divisor) through check, div1, search, setup and div2; a rejected rate
// is answered from check; one item at a time: req ready only while idle with no
// result pending, so the next item is taken only once the result is handed over;
// a held result stalls req
// synchronous active-high reset returns to idle with no result pending and the apb registers at defaults
// ---------------------------------------------------------------------------
`include "fractional_baud_divider_calc_macros.svh"

module fractional_baud_divider_calc import fbd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   fbd_req_if.sink           req_bus,
   fbd_rsp_if.source         rsp_bus,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [PaddrW-1:0] paddr,
   input  logic [DataW-1:0]  pwdata,
   output logic [DataW-1:0]  prdata,
   output logic              pready
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CHECK  = 6'b000010,
      ST_DIV1   = 6'b000100,
      ST_SEARCH = 6'b001000,
      ST_SETUP  = 6'b010000,
      ST_DIV2   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   logic [DataW-1:0]         baud_ff, baud_in;
   logic [DataW-1:0]         ratio_ff, ratio_in;
   logic                     den_nz_ff, den_nz_in;
   logic                     accepted_ff, accepted_in;
   logic [DivisorW-1:0]      divisor_ff, divisor_in;
   logic signed [ScaleW-1:0] scale_ff, scale_in;

   logic [DataW-1:0] clock_hz;
   logic             double_speed;

   div_cmd_type      div_cmd;
   div_stat_type     div_stat;
   logic [DataW-1:0] div_numer, div_denom, div_quot;

   logic [DataW-1:0]  rate_hi, rate_lo, baud_eff;
   logic              reject;
   logic [ScaleW-1:0] exp_sel;
   logic [ScaleW-1:0] sh_up, sh_dn;
   logic [DataW-1:0]  num_neg, n_calc, d_calc;
   logic              adj_one;

   fbd_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .clock_hz     (clock_hz),
      .double_speed (double_speed)
   );

   fbd_divider u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .numer (div_numer),
      .denom (div_denom),
      .stat  (div_stat),
      .quot  (div_quot)
   );

   // range limits, halved in normal speed
   always_comb begin
      if (double_speed) begin
         rate_hi  = clock_hz >> MaxRateShift;
         rate_lo  = clock_hz >> MinRateShift;
         baud_eff = baud_ff;
      end else begin
         rate_hi  = clock_hz >> (MaxRateShift + 1);
         rate_lo  = clock_hz >> (MinRateShift + 1);
         baud_eff = baud_ff << 1;
      end
      reject = (baud_ff == '0) || (baud_ff > rate_hi) || (baud_ff < rate_lo);
   end

   // lowest exponent whose limit exceeds the ratio
   always_comb begin
      exp_sel = ScaleW'(ExpSteps);
      for (int i = ExpSteps - 1; i >= 0; i--) begin
         if (ratio_ff < exp_limit(ScaleW'(i))) begin
            exp_sel = ScaleW'(i);
         end
      end
   end

   // operands of the second division, baud_ff already holds the effective rate here (doubled in normal speed)
   always_comb begin
      sh_up   = ScaleW'(unsigned'(scale_ff) + ExpBias);
      sh_dn   = ScaleW'(4'd0 - unsigned'(scale_ff) - ExpBias);
      num_neg = clock_hz - (baud_ff << 3);
      d_calc  = DataW'(baud_ff << sh_up);
      if (scale_ff[ScaleW-1]) begin
         if (scale_ff <= ExpLowBand) begin
            d_calc = baud_ff;
            n_calc = DataW'(num_neg << sh_dn) + (baud_ff >> 1);
         end else begin
            n_calc = num_neg + (d_calc >> 1);
         end
      end else begin
         n_calc = clock_hz + (d_calc >> 1);
      end
   end

   // non-negative exponents subtract one unless the divisor vanished
   assign adj_one = !scale_ff[ScaleW-1] && den_nz_ff;

   always_comb begin
      state_in      = state_ff;
      out_valid_in  = out_valid_ff;
      baud_in       = baud_ff;
      ratio_in      = ratio_ff;
      den_nz_in     = den_nz_ff;
      accepted_in   = accepted_ff;
      divisor_in    = divisor_ff;
      scale_in      = scale_ff;
      div_cmd.start = 1'b0;
      div_numer     = clock_hz;
      div_denom     = baud_eff;
      unique case (state_ff)
         ST_IDLE: begin
            if (out_valid_ff && rsp_bus.ready) begin
               out_valid_in = 1'b0;
            end
            if (!out_valid_ff && req_bus.valid) begin
               baud_in  = req_bus.baud;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (reject) begin
               accepted_in  = 1'b0;
               divisor_in   = '0;
               scale_in     = '0;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               baud_in       = baud_eff;
               div_cmd.start = 1'b1;
               state_in      = ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (div_stat.done) begin
               ratio_in = div_quot;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            scale_in = signed'(ScaleW'(exp_sel + unsigned'(ExpLow)));
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            div_cmd.start = 1'b1;
            div_numer     = n_calc;
            div_denom     = d_calc;
            den_nz_in     = (d_calc != '0);
            state_in      = ST_DIV2;
         end
         ST_DIV2: begin
            if (div_stat.done) begin
               accepted_in  = 1'b1;
               divisor_in   = DivisorW'(div_quot - {{(DataW-1){1'b0}}, adj_one});
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      baud_ff     <= baud_in;
      ratio_ff    <= ratio_in;
      den_nz_ff   <= den_nz_in;
      accepted_ff <= accepted_in;
      divisor_ff  <= divisor_in;
      scale_ff    <= scale_in;
   end

   assign req_bus.ready     = (state_ff == ST_IDLE) && !out_valid_ff;
   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.accepted  = accepted_ff;
   assign rsp_bus.divisor   = divisor_ff;
   assign rsp_bus.scale_exp = scale_ff;

   `FBD_NEVER(a_req_while_rsp, clock, reset, req_bus.ready && rsp_bus.valid, "item taken while result pending")
   `FBD_NEVER(a_start_busy, clock, reset, div_cmd.start && div_stat.busy, "divider restarted while busy")
   `FBD_ASSERT(a_reject_zero, clock, reset, (rsp_bus.valid && !rsp_bus.accepted) |-> (rsp_bus.divisor == '0 && rsp_bus.scale_exp == '0), "rejected item carries nonzero fields")
   `FBD_ASSERT(a_scale_range, clock, reset, rsp_bus.valid |-> (rsp_bus.scale_exp != -4'sd8), "scale exponent out of range")
   `FBD_ASSERT(a_done_in_div, clock, reset, div_stat.done |-> (state_ff == ST_DIV1 || state_ff == ST_DIV2), "divider finished outside a divide state")

endmodule

>>> hw/rtl/fbd_csr.sv
// ---------------------------------------------------------------------------
// fbd_csr
// apb register file holding the clock frequency and double-speed mode
// ---------------------------------------------------------------------------
module fbd_csr import fbd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [PaddrW-1:0] paddr,
   input  logic [DataW-1:0]  pwdata,
   output logic [DataW-1:0]  prdata,
   output logic              pready,
   output logic [DataW-1:0]  clock_hz,
   output logic              double_speed
);

   logic [DataW-1:0] clock_hz_ff, clock_hz_in;
   logic             dbl_ff, dbl_in;
   logic             wr_en;
   reg_idx_type      reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = reg_idx_type'(paddr[2]);

   always_comb begin
      clock_hz_in = clock_hz_ff;
      dbl_in      = dbl_ff;
      prdata      = '0;
      unique case (reg_sel)
         REG_CLOCK_HZ: begin
            prdata = clock_hz_ff;
            if (wr_en) begin
               clock_hz_in = pwdata;
            end
         end
         REG_DOUBLE_SPEED: begin
            prdata = {{(DataW-1){1'b0}}, dbl_ff};
            if (wr_en) begin
               dbl_in = pwdata[0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff <= ClockHzReset;
         dbl_ff      <= DoubleSpeedReset;
      end else begin
         clock_hz_ff <= clock_hz_in;
         dbl_ff      <= dbl_in;
      end
   end

   assign clock_hz     = clock_hz_ff;
   assign double_speed = dbl_ff;

endmodule

>>> hw/rtl/fbd_divider.sv
// ---------------------------------------------------------------------------
// fbd_divider
// shared restoring divider, one quotient bit per cycle, x/0 gives 0
// ---------------------------------------------------------------------------
module fbd_divider import fbd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  div_cmd_type      cmd,
   input  logic [DataW-1:0] numer,
   input  logic [DataW-1:0] denom,
   output div_stat_type     stat,
   output logic [DataW-1:0] quot
);

   logic [DataW:0]       rem_ff, rem_in;
   logic [DataW-1:0]     q_ff, q_in;
   logic [DataW-1:0]     den_ff, den_in;
   logic                 den_zero_ff, den_zero_in;
   logic [DivCountW-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DataW:0]       rem_shift;
   logic [DataW:0]       rem_diff;

   assign rem_shift = {rem_ff[DataW-1:0], q_ff[DataW-1]};
   assign rem_diff  = rem_shift - {1'b0, den_ff};

   always_comb begin
      rem_in      = rem_ff;
      q_in        = q_ff;
      den_in      = den_ff;
      den_zero_in = den_zero_ff;
      cnt_in      = cnt_ff;
      busy_in     = busy_ff;
      done_in     = 1'b0;
      if (cmd.start) begin
         rem_in      = '0;
         q_in        = numer;
         den_in      = denom;
         den_zero_in = (denom == '0);
         cnt_in      = '1;
         busy_in     = 1'b1;
      end else if (busy_ff) begin
         if (!rem_diff[DataW]) begin
            rem_in = rem_diff;
            q_in   = {q_ff[DataW-2:0], 1'b1};
         end else begin
            rem_in = rem_shift;
            q_in   = {q_ff[DataW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - {{(DivCountW-1){1'b0}}, 1'b1};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff      <= rem_in;
      q_ff        <= q_in;
      den_ff      <= den_in;
      den_zero_ff <= den_zero_in;
      cnt_ff      <= cnt_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = den_zero_ff ? '0 : q_ff;

endmodule

>>> bench/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top - fractional baud divider calculation testbench
// drives requested baud rates through a queue-fed driver under random gaps,
// predicts accept flag, divisor and scale exponent for every item and checks
// each result in order; sweeps clock and double-speed settings over the apb
// port between phases, including the extremes and a zero clock
// ---------------------------------------------------------------------------
module tb_top import fbd_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int IdleLimit = 20000;
   localparam int DrainCycles = 80;

   typedef struct packed {
      logic                     accepted;
      logic [DivisorW-1:0]      divisor;
      logic signed [ScaleW-1:0] scale_exp;
   } baud_select_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [PaddrW-1:0] paddr;
   logic [DataW-1:0]  pwdata;
   logic [DataW-1:0]  prdata;
   logic              pready;

   fbd_req_if req_bus ();
   fbd_rsp_if rsp_bus ();

   fractional_baud_divider_calc i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   logic [DataW-1:0] cfg_clock_hz = ClockHzReset;
   logic             cfg_double_speed = DoubleSpeedReset;
   bit               burst_mode = 1'b0;

   logic [DataW-1:0] pending_bauds[$];
   baud_select_type  expected_selects[$];
   int               mismatch_count = 0;
   int               send_gap;
   int               recv_stall;
   int               recv_hold;
   bit               hold_done;
   int               results_seen = 0;
   int               idle_cycles = 0;

   // bsel/bscale selection, 32-bit wrapping as the hardware does
   function automatic baud_select_type predict_baud_select(input logic [DataW-1:0] baud_in,
                                                           input logic [DataW-1:0] clk,
                                                           input logic dbl);
      logic [DataW-1:0] baud, hi, lo, lim, ratio, num, den, sum, quo;
      int               e;
      baud_select_type  sel;
      sel = '0;
      baud = baud_in;
      hi = clk >> MaxRateShift;
      lo = clk >> MinRateShift;
      if (!dbl) begin
         hi = hi >> 1;
         lo = lo >> 1;
      end
      if (baud == 0 || baud > hi || baud < lo) return sel;
      if (!dbl) baud = baud << 1;
      lim = 32'h0000_00FF;
      ratio = clk / baud;
      for (e = -7; e < 7; e++) begin
         if (ratio < lim) break;
         lim = lim << 1;
         if (e < -3) lim[0] = 1'b1;
      end
      if (e < 0) begin
         num = clk - (baud << 3);
         if (e <= -3) begin
            num = num << (-e - 3);
            den = baud;
         end else begin
            den = baud << (e + 3);
         end
         sum = num + (den >> 1);
         quo = (den == 0) ? 32'd0 : sum / den;
      end else begin
         den = baud << (e + 3);
         if (den == 0) begin
            quo = 32'd0;
         end else begin
            sum = clk + (den >> 1);
            quo = sum / den;
            quo = quo - 32'd1;
         end
      end
      sel.accepted = 1'b1;
      sel.divisor = quo[DivisorW-1:0];
      sel.scale_exp = ScaleW'(e);
      return sel;
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap(input bit no_idle);
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 65) return 0;
      if (r < 95) return $urandom_range(1, 4);
      return $urandom_range(20, 150);
   endfunction

   // rates spread over every exponent band, with bounds and raw noise mixed in
   function automatic logic [DataW-1:0] random_baud();
      logic [DataW-1:0] eff, hi, lo, base;
      int               r;
      eff = cfg_double_speed ? cfg_clock_hz : cfg_clock_hz >> 1;
      hi = eff >> MaxRateShift;
      lo = eff >> MinRateShift;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         base = eff >> $urandom_range(MaxRateShift, MinRateShift);
         return base + $urandom_range(0, base >> 2);
      end
      if (r < 75) return $urandom_range(hi, lo);
      if (r < 85) begin
         case ($urandom_range(0, 5))
            0: return lo - 32'd1;
            1: return lo;
            2: return lo + 32'd1;
            3: return hi - 32'd1;
            4: return hi;
            default: return hi + 32'd1;
         endcase
      end
      if (r < 97) return $urandom();
      return 32'd0;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            expected_selects.push_back(predict_baud_select(req_bus.baud, cfg_clock_hz,
                                                           cfg_double_speed));
         if (req_bus.valid && !req_bus.ready) begin
            // keep offering the same item
         end else if (send_gap != 0) begin
            req_bus.valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (pending_bauds.size() != 0) begin
            req_bus.valid <= 1'b1;
            req_bus.baud <= pending_bauds.pop_front();
            send_gap <= pick_gap(burst_mode);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // monitor and result sink
   always @(posedge clock) begin
      baud_select_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_stall <= 0;
         recv_hold <= 0;
         hold_done <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (expected_selects.size() == 0) begin
               mismatch_count++;
               $display("%0t unexpected item: accepted %0b divisor %0d scale_exp %0d",
                        $realtime, rsp_bus.accepted, rsp_bus.divisor, rsp_bus.scale_exp);
            end else begin
               want = expected_selects.pop_front();
               if (rsp_bus.accepted !== want.accepted) begin
                  mismatch_count++;
                  $display("%0t accepted: expected %0b actual %0b",
                           $realtime, want.accepted, rsp_bus.accepted);
               end
               if (rsp_bus.divisor !== want.divisor) begin
                  mismatch_count++;
                  $display("%0t divisor: expected %0d actual %0d",
                           $realtime, want.divisor, rsp_bus.divisor);
               end
               if (rsp_bus.scale_exp !== want.scale_exp) begin
                  mismatch_count++;
                  $display("%0t scale_exp: expected %0d actual %0d",
                           $realtime, want.scale_exp, rsp_bus.scale_exp);
               end
            end
         end
         // one long hold-off so the block backs up onto its input
         if (recv_hold != 0) begin
            rsp_bus.ready <= 1'b0;
            recv_hold <= recv_hold - 1;
         end else if (!hold_done && results_seen >= 200) begin
            rsp_bus.ready <= 1'b0;
            recv_hold <= 800;
            hold_done <= 1'b1;
         end else if (recv_stall != 0) begin
            rsp_bus.ready <= 1'b0;
            recv_stall <= recv_stall - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
            recv_stall <= pick_gap(burst_mode);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic csr_write(input reg_idx_type idx, input logic [DataW-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (idx == REG_CLOCK_HZ)
         cfg_clock_hz = value;
      else
         cfg_double_speed = value[0];
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending_bauds.size() != 0 || req_bus.valid || expected_selects.size() != 0)
         @(negedge clock);
   endtask

   task automatic run_phase(input logic [DataW-1:0] clk, input logic dbl, input int n_items);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_write(REG_CLOCK_HZ, clk);
      csr_write(REG_DOUBLE_SPEED, {31'd0, dbl});
      @(negedge clock);
      burst_mode = ($urandom_range(0, 3) == 0);
      repeat (n_items) pending_bauds.push_back(random_baud());
   endtask

   initial begin
      logic [DataW-1:0] eff;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.baud = '0;
      rsp_bus.ready = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: bounds, zero, wide values and rates at power-of-two steps over most exponent bands
      eff = cfg_clock_hz >> 1;
      pending_bauds.push_back(32'd0);
      pending_bauds.push_back(32'd1);
      pending_bauds.push_back((eff >> MaxRateShift) - 32'd1);
      pending_bauds.push_back(eff >> MaxRateShift);
      pending_bauds.push_back((eff >> MaxRateShift) + 32'd1);
      pending_bauds.push_back(32'hFFFF_FFFF);
      pending_bauds.push_back(32'h8000_0000);
      pending_bauds.push_back(32'h5555_5555);
      pending_bauds.push_back(32'hAAAA_AAAA);
      for (int k = 3; k <= 18; k++) pending_bauds.push_back(eff >> k);
      repeat (100) pending_bauds.push_back(random_baud());

      run_phase(32'd32_000_000, 1'b1, 150);
      run_phase(32'hFFFF_FFFF, 1'b1, 150);
      run_phase(32'hFFFF_FFFF, 1'b0, 150);
      run_phase(32'd1, 1'b0, 20);
      run_phase(32'd1, 1'b1, 20);
      // zero clock rejects everything
      run_phase(32'd0, 1'b1, 10);
      run_phase(32'd16_000_000, 1'b0, 150);
      run_phase(32'd7_372_800, 1'b1, 150);
      repeat (5) begin
         run_phase($urandom_range(0, 1) ? $urandom() : $urandom_range(1000, 100_000_000),
                   1'($urandom_range(0, 1)), 150);
      end

      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/fbd_pkg.sv
hw/rtl/fbd_req_if.sv
hw/rtl/fbd_rsp_if.sv
hw/rtl/fbd_csr.sv
hw/rtl/fbd_divider.sv
hw/rtl/fractional_baud_divider_calc.sv
bench/tb_top.sv
